/* hdl/udp_ff_pkg.sv */
// ============================================================================
// udp_ff_pkg: shared types and constants of the UDP frame filter
// Holds the configuration and result structs, verdict codes, register
// indexes and the default values used by the modules of the filter.
// ============================================================================
package udp_ff_pkg;

    // Frame size limit; bytes at or beyond it are ignored.
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_IP   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEER_IP    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEER_PORT  = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [31:0] LOCAL_IP_RST   = 32'd0;
    localparam logic [31:0] PEER_IP_RST    = 32'd0;
    localparam logic [15:0] LOCAL_PORT_RST = 16'd7777;
    localparam logic [15:0] PEER_PORT_RST  = 16'd9999;

    // Fixed header layout and values.
    localparam logic [7:0] ETYPE_HI      = 8'h08;
    localparam logic [7:0] ETYPE_LO      = 8'h00;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [3:0] MIN_IHL       = 4'd5;
    localparam logic [6:0] IP_HDR_START  = 7'd14;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    // Bit positions of the per-check failure flags.
    localparam int FAIL_ETYPE    = 0;
    localparam int FAIL_PROTO    = 1;
    localparam int FAIL_DST_IP   = 2;
    localparam int FAIL_SRC_IP   = 3;
    localparam int FAIL_DST_PORT = 4;
    localparam int FAIL_SRC_PORT = 5;
    localparam int FAIL_W        = 6;

    // Frame verdict codes.
    typedef enum logic [3:0] {
        VERDICT_ACCEPT    = 4'd0,
        VERDICT_ETYPE     = 4'd1,
        VERDICT_PROTO     = 4'd2,
        VERDICT_DST_IP    = 4'd3,
        VERDICT_SRC_IP    = 4'd4,
        VERDICT_DST_PORT  = 4'd5,
        VERDICT_SRC_PORT  = 4'd6,
        VERDICT_SHORT     = 4'd7,
        VERDICT_UDP_LEN   = 4'd8,
        VERDICT_TRUNCATED = 4'd9
    } verdict_t;

    // Filter settings handed from the register block to the parser.
    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] peer_ip;
        logic [15:0] local_port;
        logic [15:0] peer_port;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       payload_last;
        logic       frame_end;
        verdict_t   verdict;
    } result_t;

endpackage

/* hdl/udp_ff_cfg.sv */
// ============================================================================
// udp_ff_cfg: configuration registers of the UDP frame filter
// Takes register writes by index and holds the address and port settings.
// ============================================================================
module udp_ff_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [udp_ff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [udp_ff_pkg::CFG_DATA_W-1:0]   cfg_data,
    output udp_ff_pkg::cfg_t                    cfg
);

    udp_ff_pkg::cfg_t cfg_reg;
    udp_ff_pkg::cfg_t cfg_next;

    // Writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // Select the register addressed by the transfer; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                udp_ff_pkg::CFG_LOCAL_IP:   cfg_next.local_ip   = cfg_data;
                udp_ff_pkg::CFG_PEER_IP:    cfg_next.peer_ip    = cfg_data;
                udp_ff_pkg::CFG_LOCAL_PORT: cfg_next.local_port = cfg_data[15:0];
                udp_ff_pkg::CFG_PEER_PORT:  cfg_next.peer_port  = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_ip   <= udp_ff_pkg::LOCAL_IP_RST;
            cfg_reg.peer_ip    <= udp_ff_pkg::PEER_IP_RST;
            cfg_reg.local_port <= udp_ff_pkg::LOCAL_PORT_RST;
            cfg_reg.peer_port  <= udp_ff_pkg::PEER_PORT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/udp_ff_in_reg.sv */
// ============================================================================
// udp_ff_in_reg: input register of the UDP frame filter
// Holds one accepted frame byte until the parser takes it.
// ============================================================================
module udp_ff_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // A new byte may enter when the register is empty or is being drained.
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload captures on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

/* hdl/udp_ff_parse.sv */
// ============================================================================
// udp_ff_parse: header parser of the UDP frame filter
// Tracks the byte offset in the frame, checks the header fields against the
// settings, counts payload bytes and forms the result for each byte.
// ============================================================================
module udp_ff_parse #(
    parameter int MAX_FRAME_BYTES = udp_ff_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  udp_ff_pkg::cfg_t        cfg,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    output logic                    res_produce,
    output udp_ff_pkg::result_t     res
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);

    // Per-frame state.
    logic [OFF_W-1:0]              off_reg, off_next;
    logic [3:0]                    hdr_reg, hdr_next;
    logic [udp_ff_pkg::FAIL_W-1:0] fail_reg, fail_next;
    logic [15:0]                   len_reg, len_next;
    logic [15:0]                   cnt_reg, cnt_next;
    logic                          ok_reg, ok_next;

    logic [3:0]       hw_cur, hw_new;
    logic [6:0]       udp_cur, udp_new;
    logic [OFF_W-1:0] u;
    logic [OFF_W-1:0] u_new;
    logic             in_range;
    logic             pv;
    logic             pl;
    logic [15:0]      pay_len;
    logic [15:0]      pay_len_new;
    logic [15:0]      cnt_inc;
    udp_ff_pkg::verdict_t verdict;

    // UDP header start from the IHL nibble, small values taken as the minimum.
    assign hw_cur  = (hdr_reg < udp_ff_pkg::MIN_IHL) ? udp_ff_pkg::MIN_IHL : hdr_reg;
    assign udp_cur = udp_ff_pkg::IP_HDR_START + {1'b0, hw_cur, 2'b00};
    assign u       = OFF_W'(udp_cur);
    assign hw_new  = (hdr_next < udp_ff_pkg::MIN_IHL) ? udp_ff_pkg::MIN_IHL : hdr_next;
    assign udp_new = udp_ff_pkg::IP_HDR_START + {1'b0, hw_new, 2'b00};
    assign u_new   = OFF_W'(udp_new);

    assign in_range = off_reg < OFF_MAX;
    assign pay_len  = len_reg - udp_ff_pkg::UDP_HDR_BYTES;
    assign cnt_inc  = cnt_reg + 16'd1;

    // Field checks, length capture and payload selection for the current byte.
    always_comb begin
        off_next  = off_reg;
        hdr_next  = hdr_reg;
        fail_next = fail_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        ok_next   = ok_reg;
        pv        = 1'b0;
        pl        = 1'b0;
        if (in_range) begin
            // EtherType must be IPv4.
            if ((off_reg == OFF_W'(12) && in_byte != udp_ff_pkg::ETYPE_HI) ||
                (off_reg == OFF_W'(13) && in_byte != udp_ff_pkg::ETYPE_LO)) begin
                fail_next[udp_ff_pkg::FAIL_ETYPE] = 1'b1;
            end
            if (off_reg == OFF_W'(14)) begin
                hdr_next = in_byte[3:0];
            end
            if (off_reg == OFF_W'(23) && in_byte != udp_ff_pkg::PROTO_UDP) begin
                fail_next[udp_ff_pkg::FAIL_PROTO] = 1'b1;
            end
            // Source address, most significant byte first.
            if ((off_reg == OFF_W'(26) && in_byte != cfg.peer_ip[31:24]) ||
                (off_reg == OFF_W'(27) && in_byte != cfg.peer_ip[23:16]) ||
                (off_reg == OFF_W'(28) && in_byte != cfg.peer_ip[15:8])  ||
                (off_reg == OFF_W'(29) && in_byte != cfg.peer_ip[7:0])) begin
                fail_next[udp_ff_pkg::FAIL_SRC_IP] = 1'b1;
            end
            // Destination address.
            if ((off_reg == OFF_W'(30) && in_byte != cfg.local_ip[31:24]) ||
                (off_reg == OFF_W'(31) && in_byte != cfg.local_ip[23:16]) ||
                (off_reg == OFF_W'(32) && in_byte != cfg.local_ip[15:8])  ||
                (off_reg == OFF_W'(33) && in_byte != cfg.local_ip[7:0])) begin
                fail_next[udp_ff_pkg::FAIL_DST_IP] = 1'b1;
            end
            // UDP source and destination ports.
            if ((off_reg == u && in_byte != cfg.peer_port[15:8]) ||
                (off_reg == u + OFF_W'(1) && in_byte != cfg.peer_port[7:0])) begin
                fail_next[udp_ff_pkg::FAIL_SRC_PORT] = 1'b1;
            end
            if ((off_reg == u + OFF_W'(2) && in_byte != cfg.local_port[15:8]) ||
                (off_reg == u + OFF_W'(3) && in_byte != cfg.local_port[7:0])) begin
                fail_next[udp_ff_pkg::FAIL_DST_PORT] = 1'b1;
            end
            // UDP length; the frame is good once it is complete and all checks pass.
            if (off_reg == u + OFF_W'(4)) begin
                len_next = {in_byte, 8'h00};
            end
            if (off_reg == u + OFF_W'(5)) begin
                len_next = {len_reg[15:8], in_byte};
                ok_next  = (fail_next == '0) && (len_next >= udp_ff_pkg::UDP_HDR_BYTES);
            end
            // Payload passes until the UDP length is used up.
            if (off_reg >= u + OFF_W'(8) && ok_reg && cnt_reg < pay_len) begin
                pv       = 1'b1;
                cnt_next = cnt_inc;
                pl       = (cnt_inc == pay_len);
            end
            off_next = off_reg + OFF_W'(1);
        end
    end

    assign pay_len_new = len_next - udp_ff_pkg::UDP_HDR_BYTES;

    // Verdict from the state after this byte; the first failed check in the order below wins.
    always_comb begin
        priority if (fail_next[udp_ff_pkg::FAIL_ETYPE]) begin
            verdict = udp_ff_pkg::VERDICT_ETYPE;
        end else if (fail_next[udp_ff_pkg::FAIL_PROTO]) begin
            verdict = udp_ff_pkg::VERDICT_PROTO;
        end else if (fail_next[udp_ff_pkg::FAIL_DST_IP]) begin
            verdict = udp_ff_pkg::VERDICT_DST_IP;
        end else if (fail_next[udp_ff_pkg::FAIL_SRC_IP]) begin
            verdict = udp_ff_pkg::VERDICT_SRC_IP;
        end else if (fail_next[udp_ff_pkg::FAIL_DST_PORT]) begin
            verdict = udp_ff_pkg::VERDICT_DST_PORT;
        end else if (fail_next[udp_ff_pkg::FAIL_SRC_PORT]) begin
            verdict = udp_ff_pkg::VERDICT_SRC_PORT;
        end else if (off_next < u_new + OFF_W'(8)) begin
            verdict = udp_ff_pkg::VERDICT_SHORT;
        end else if (len_next < udp_ff_pkg::UDP_HDR_BYTES) begin
            verdict = udp_ff_pkg::VERDICT_UDP_LEN;
        end else if (cnt_next < pay_len_new) begin
            verdict = udp_ff_pkg::VERDICT_TRUNCATED;
        end else begin
            verdict = udp_ff_pkg::VERDICT_ACCEPT;
        end
    end

    // Result fields, zero where they carry nothing.
    assign res_produce       = pv || in_last;
    assign res.payload_valid = pv;
    assign res.payload_byte  = pv ? in_byte : 8'h00;
    assign res.payload_last  = pl;
    assign res.frame_end     = in_last;
    assign res.verdict       = in_last ? verdict : udp_ff_pkg::VERDICT_ACCEPT;

    // State advances on each byte and clears after the frame's final byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= '0;
            hdr_reg  <= '0;
            fail_reg <= '0;
            len_reg  <= '0;
            cnt_reg  <= '0;
            ok_reg   <= 1'b0;
        end else if (step) begin
            if (in_last) begin
                off_reg  <= '0;
                hdr_reg  <= '0;
                fail_reg <= '0;
                len_reg  <= '0;
                cnt_reg  <= '0;
                ok_reg   <= 1'b0;
            end else begin
                off_reg  <= off_next;
                hdr_reg  <= hdr_next;
                fail_reg <= fail_next;
                len_reg  <= len_next;
                cnt_reg  <= cnt_next;
                ok_reg   <= ok_next;
            end
        end
    end

endmodule

/* hdl/udp_ff_out_reg.sv */
// ============================================================================
// udp_ff_out_reg: result register of the UDP frame filter
// Holds one result item until the downstream side takes it.
// ============================================================================
module udp_ff_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  udp_ff_pkg::result_t  res,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic [5:0]           m_tuser
);

    logic                valid_reg;
    logic                valid_next;
    udp_ff_pkg::result_t res_reg;

    // The register can take a new result when empty or being emptied.
    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tlast  = res_reg.payload_last;
    assign m_tuser  = {res_reg.verdict, res_reg.frame_end, res_reg.payload_valid};

endmodule

/* hdl/udp_frame_filter_core.sv */
// ============================================================================
// udp_frame_filter_core: Ethernet / IPv4 / UDP header filter
// Checks each frame's EtherType, protocol, addresses and ports against the
// settings and passes the UDP payload of matching frames, with a verdict on
// every frame's final byte.
// ============================================================================
//
//  Channel   Direction  Contents
//  s_        in         frame bytes, tlast on the final byte of the frame
//  m_        out        payload bytes and frame verdicts
//  cfg_      in         register writes: 0 local_ip, 1 peer_ip,
//                       2 local_port, 3 peer_port
//
//  One frame byte can be taken every cycle. The byte waits in the input
//  register until the result register has room, and its result, if any, is
//  then loaded into the result register, which drives m_tvalid.
//  A byte that yields no result takes no output slot, but it still waits
//  while the result register is full and m_tready is low.
//  In that case the parse stage holds and s_tready drops once the input
//  register is also occupied.
//  aresetn is synchronous and active low; it clears the frame state and
//  loads the register defaults. Configuration writes complete at once.
//
module udp_frame_filter_core #(
    parameter int MAX_FRAME_BYTES = udp_ff_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] frame_byte
    input  logic                                s_tlast,   // frame_last
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] payload_byte
    output logic                                m_tlast,   // payload_last
    output logic [5:0]                          m_tuser,   // [0] payload_valid,
                                                           // [1] frame_end,
                                                           // [5:2] verdict
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [udp_ff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [udp_ff_pkg::CFG_DATA_W-1:0]   cfg_data
);

    udp_ff_pkg::cfg_t    cfg;
    udp_ff_pkg::result_t res;
    logic                held_valid;
    logic [7:0]          held_byte;
    logic                held_last;
    logic                space;
    logic                step;
    logic                res_produce;

    // A held byte is processed whenever the result register has room.
    assign step = held_valid && space;

    udp_ff_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    udp_ff_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    udp_ff_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .step        (step),
        .in_byte     (held_byte),
        .in_last     (held_last),
        .res_produce (res_produce),
        .res         (res)
    );

    udp_ff_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_produce),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/udp_frame_filter_core_tb.sv */
// ============================================================================
// udp_frame_filter_core_tb: self-checking bench for the UDP frame filter
// Streams whole Ethernet frames (well-formed, damaged, cut short and random
// noise) through the filter under several address and port settings. A
// tracker class works out every payload byte and verdict the filter should
// emit and checks each output transfer against them in order.
// ============================================================================
module udp_frame_filter_core_tb;

    localparam int          PHASE_COUNT  = 5;
    localparam int unsigned PHASE_BYTES  = 270;
    localparam int          PIPE_SETTLE  = 8;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;

    // Kinds of frames the stimulus builds.
    typedef enum int {
        FR_GOOD,
        FR_TRUNC,
        FR_SMALL_LEN,
        FR_BAD_FIELD,
        FR_SHORT,
        FR_NOISE
    } frame_kind_e;

    // Tracks one frame at a time and predicts the outputs of the filter.
    class filter_verdict_tracker;
        udp_ff_pkg::cfg_t    settings;
        int unsigned         offset;
        logic [3:0]          ihl;
        logic [5:0]          fails;
        logic [15:0]         udp_len;
        int unsigned         pay_cnt;
        bit                  ok;
        udp_ff_pkg::result_t due_results[$];
        int                  errors;

        function new();
            settings.local_ip   = udp_ff_pkg::LOCAL_IP_RST;
            settings.peer_ip    = udp_ff_pkg::PEER_IP_RST;
            settings.local_port = udp_ff_pkg::LOCAL_PORT_RST;
            settings.peer_port  = udp_ff_pkg::PEER_PORT_RST;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            offset  = 0;
            ihl     = '0;
            fails   = '0;
            udp_len = '0;
            pay_cnt = 0;
            ok      = 1'b0;
        endfunction

        function int unsigned udp_hdr_start();
            return udp_ff_pkg::IP_HDR_START
                   + 4 * (ihl < udp_ff_pkg::MIN_IHL ? udp_ff_pkg::MIN_IHL : ihl);
        endfunction

        function void write_reg(logic [udp_ff_pkg::CFG_INDEX_W-1:0] idx,
                                logic [udp_ff_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                udp_ff_pkg::CFG_LOCAL_IP:   settings.local_ip   = val;
                udp_ff_pkg::CFG_PEER_IP:    settings.peer_ip    = val;
                udp_ff_pkg::CFG_LOCAL_PORT: settings.local_port = val[15:0];
                udp_ff_pkg::CFG_PEER_PORT:  settings.peer_port  = val[15:0];
                default: ;
            endcase
        endfunction

        // Advances the frame state by one accepted byte and queues its output.
        function void take_frame_byte(logic [7:0] b, logic last);
            udp_ff_pkg::result_t  r;
            int unsigned          u;
            bit                   pv;
            bit                   pl;
            udp_ff_pkg::verdict_t v;
            pv = 1'b0;
            pl = 1'b0;
            if (offset < udp_ff_pkg::MAX_FRAME_BYTES_DEF) begin
                u = udp_hdr_start();
                if ((offset == 12 && b != udp_ff_pkg::ETYPE_HI) ||
                    (offset == 13 && b != udp_ff_pkg::ETYPE_LO)) begin
                    fails[udp_ff_pkg::FAIL_ETYPE] = 1'b1;
                end
                if (offset == 14) begin
                    ihl = b[3:0];
                end
                if (offset == 23 && b != udp_ff_pkg::PROTO_UDP) begin
                    fails[udp_ff_pkg::FAIL_PROTO] = 1'b1;
                end
                if (offset >= 26 && offset <= 29 &&
                    settings.peer_ip[8 * (29 - offset) +: 8] != b) begin
                    fails[udp_ff_pkg::FAIL_SRC_IP] = 1'b1;
                end
                if (offset >= 30 && offset <= 33 &&
                    settings.local_ip[8 * (33 - offset) +: 8] != b) begin
                    fails[udp_ff_pkg::FAIL_DST_IP] = 1'b1;
                end
                if ((offset == u && settings.peer_port[15:8] != b) ||
                    (offset == u + 1 && settings.peer_port[7:0] != b)) begin
                    fails[udp_ff_pkg::FAIL_SRC_PORT] = 1'b1;
                end
                if ((offset == u + 2 && settings.local_port[15:8] != b) ||
                    (offset == u + 3 && settings.local_port[7:0] != b)) begin
                    fails[udp_ff_pkg::FAIL_DST_PORT] = 1'b1;
                end
                if (offset == u + 4) begin
                    udp_len = {b, 8'h00};
                end
                if (offset == u + 5) begin
                    udp_len[7:0] = b;
                    ok = (fails == '0) && (udp_len >= udp_ff_pkg::UDP_HDR_BYTES);
                end
                // Payload passes only after the whole UDP header, up to its length.
                if (offset >= u + udp_ff_pkg::UDP_HDR_BYTES && ok &&
                    pay_cnt < udp_len - udp_ff_pkg::UDP_HDR_BYTES) begin
                    pv = 1'b1;
                    pay_cnt++;
                    pl = (pay_cnt == udp_len - udp_ff_pkg::UDP_HDR_BYTES);
                end
                offset++;
            end
            if (!pv && !last) begin
                return;
            end

            // The first failed check in the order below decides the verdict.
            v = udp_ff_pkg::VERDICT_ACCEPT;
            if (last) begin
                u = udp_hdr_start();
                if (fails[udp_ff_pkg::FAIL_ETYPE]) begin
                    v = udp_ff_pkg::VERDICT_ETYPE;
                end else if (fails[udp_ff_pkg::FAIL_PROTO]) begin
                    v = udp_ff_pkg::VERDICT_PROTO;
                end else if (fails[udp_ff_pkg::FAIL_DST_IP]) begin
                    v = udp_ff_pkg::VERDICT_DST_IP;
                end else if (fails[udp_ff_pkg::FAIL_SRC_IP]) begin
                    v = udp_ff_pkg::VERDICT_SRC_IP;
                end else if (fails[udp_ff_pkg::FAIL_DST_PORT]) begin
                    v = udp_ff_pkg::VERDICT_DST_PORT;
                end else if (fails[udp_ff_pkg::FAIL_SRC_PORT]) begin
                    v = udp_ff_pkg::VERDICT_SRC_PORT;
                end else if (offset < u + udp_ff_pkg::UDP_HDR_BYTES) begin
                    v = udp_ff_pkg::VERDICT_SHORT;
                end else if (udp_len < udp_ff_pkg::UDP_HDR_BYTES) begin
                    v = udp_ff_pkg::VERDICT_UDP_LEN;
                end else if (pay_cnt < udp_len - udp_ff_pkg::UDP_HDR_BYTES) begin
                    v = udp_ff_pkg::VERDICT_TRUNCATED;
                end
            end
            r.payload_valid = pv;
            r.payload_byte  = pv ? b : 8'h00;
            r.payload_last  = pl;
            r.frame_end     = last;
            r.verdict       = v;
            due_results.push_back(r);
            if (last) begin
                clear_frame();
            end
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Compares one output transfer with the oldest prediction.
        function void match_output(logic [7:0] data, logic tlast, logic [5:0] user);
            udp_ff_pkg::result_t e;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual data %0h last %0b user %0h",
                         $time, data, tlast, user);
                errors++;
                return;
            end
            e = due_results.pop_front();
            check_field("payload_valid", e.payload_valid, user[0]);
            check_field("payload_byte", e.payload_byte, data);
            check_field("payload_last", e.payload_last, tlast);
            check_field("frame_end", e.frame_end, user[1]);
            check_field("verdict", e.verdict, user[5:2]);
        endfunction

        function void report_leftovers();
            foreach (due_results[i]) begin
                $display("%0t: missing output, expected %0h, actual none", $time, due_results[i]);
                errors++;
            end
            due_results.delete();
        endfunction
    endclass

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata   = 8'h00;
    logic                                s_tlast   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [7:0]                          m_tdata;
    logic                                m_tlast;
    logic [5:0]                          m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [udp_ff_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [udp_ff_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    filter_verdict_tracker tracker;
    logic [7:0]            frame_q[$];
    int unsigned           sent_bytes  = 0;
    int                    cycle_count = 0;

    udp_frame_filter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run time guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Every output transfer is checked at the edge that completes it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.match_output(m_tdata, m_tlast, m_tuser);
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output side back-pressure: runs of ready broken by stalls.
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 8))
                @(posedge aclk);
            gap = pick_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Sends frame_q, one transfer per byte, with tlast on the final byte.
    task automatic send_frame();
        bit steady;
        int gap;
        steady = ($urandom_range(0, 3) == 0);
        foreach (frame_q[i]) begin
            gap = steady ? 0 : pick_gap();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            do @(posedge aclk); while (!s_tready);
            tracker.take_frame_byte(frame_q[i], i == frame_q.size() - 1);
            sent_bytes++;
        end
    endtask

    // Lets the filter empty out before settings change or the run ends.
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [udp_ff_pkg::CFG_INDEX_W-1:0] idx,
                             logic [udp_ff_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, val);
    endtask

    task automatic apply_settings(udp_ff_pkg::cfg_t c);
        wait_idle();
        write_reg(udp_ff_pkg::CFG_LOCAL_IP, c.local_ip);
        write_reg(udp_ff_pkg::CFG_PEER_IP, c.peer_ip);
        write_reg(udp_ff_pkg::CFG_LOCAL_PORT, {16'h0000, c.local_port});
        write_reg(udp_ff_pkg::CFG_PEER_PORT, {16'h0000, c.peer_port});
        cfg_valid <= 1'b0;
    endtask

    // Builds an Ethernet / IPv4 / UDP frame that matches the current settings,
    // followed by tail bytes of random payload and padding.
    task automatic build_udp_frame(logic [3:0] hdr_nibble, int unsigned tail,
                                   logic [15:0] ulen);
        int unsigned ip_end;
        int          k;
        ip_end = udp_ff_pkg::IP_HDR_START
                 + 4 * (hdr_nibble < udp_ff_pkg::MIN_IHL ? udp_ff_pkg::MIN_IHL : hdr_nibble);
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        frame_q.push_back(udp_ff_pkg::ETYPE_HI);
        frame_q.push_back(udp_ff_pkg::ETYPE_LO);
        frame_q.push_back({4'($urandom), hdr_nibble});
        repeat (8) frame_q.push_back(8'($urandom));
        frame_q.push_back(udp_ff_pkg::PROTO_UDP);
        repeat (2) frame_q.push_back(8'($urandom));
        for (k = 3; k >= 0; k--) frame_q.push_back(tracker.settings.peer_ip[8 * k +: 8]);
        for (k = 3; k >= 0; k--) frame_q.push_back(tracker.settings.local_ip[8 * k +: 8]);
        // IP options, if any.
        while (frame_q.size() < ip_end) frame_q.push_back(8'($urandom));
        frame_q.push_back(tracker.settings.peer_port[15:8]);
        frame_q.push_back(tracker.settings.peer_port[7:0]);
        frame_q.push_back(tracker.settings.local_port[15:8]);
        frame_q.push_back(tracker.settings.local_port[7:0]);
        frame_q.push_back(ulen[15:8]);
        frame_q.push_back(ulen[7:0]);
        repeat (2) frame_q.push_back(8'($urandom));
        repeat (tail) frame_q.push_back(8'($urandom));
    endtask

    task automatic make_frame(frame_kind_e kind);
        logic [3:0]  hdr_nibble;
        int unsigned plen;
        int unsigned pad;
        int unsigned u;
        int unsigned pos;
        int          r;
        logic [15:0] ulen;
        // IHL is mostly 5; sometimes below (taken as 5) or with options.
        r = $urandom_range(0, 9);
        hdr_nibble = (r < 7) ? udp_ff_pkg::MIN_IHL
                   : (r == 7) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(6, 15));
        u    = udp_ff_pkg::IP_HDR_START
               + 4 * (hdr_nibble < udp_ff_pkg::MIN_IHL ? udp_ff_pkg::MIN_IHL : hdr_nibble);
        plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
        pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (kind == FR_NOISE) begin
            frame_q.delete();
            repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
            return;
        end
        ulen = 16'(udp_ff_pkg::UDP_HDR_BYTES + plen);
        if (kind == FR_TRUNC) begin
            ulen = ($urandom_range(0, 4) == 0)
                   ? 16'hFFFF
                   : 16'(udp_ff_pkg::UDP_HDR_BYTES + plen + $urandom_range(1, 20));
            pad = 0;
        end else if (kind == FR_SMALL_LEN) begin
            ulen = 16'($urandom_range(0, 7));
        end
        build_udp_frame(hdr_nibble, plen + pad, ulen);
        if (kind == FR_BAD_FIELD) begin
            // One or two checked fields get a wrong byte.
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, udp_ff_pkg::FAIL_W - 1))
                    udp_ff_pkg::FAIL_ETYPE:    pos = $urandom_range(12, 13);
                    udp_ff_pkg::FAIL_PROTO:    pos = 23;
                    udp_ff_pkg::FAIL_DST_IP:   pos = $urandom_range(30, 33);
                    udp_ff_pkg::FAIL_SRC_IP:   pos = $urandom_range(26, 29);
                    udp_ff_pkg::FAIL_DST_PORT: pos = $urandom_range(u + 2, u + 3);
                    default:                   pos = $urandom_range(u, u + 1);
                endcase
                frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
            end
        end else if (kind == FR_SHORT) begin
            // Ends somewhere before the UDP header is complete.
            pos = $urandom_range(1, u + udp_ff_pkg::UDP_HDR_BYTES - 1);
            while (frame_q.size() > pos) void'(frame_q.pop_back());
        end
    endtask

    // Random frames until the byte budget is spent; the first pass of the
    // run visits every frame kind once before choosing at random.
    task automatic run_frames(int unsigned budget, bit ordered);
        int unsigned start;
        int          n;
        int          r;
        frame_kind_e kind;
        start = sent_bytes;
        n = 0;
        while (sent_bytes - start < budget) begin
            r = $urandom_range(0, 99);
            if (ordered && n <= FR_NOISE) begin
                kind = frame_kind_e'(n);
            end else if (r < 45) begin
                kind = FR_GOOD;
            end else if (r < 55) begin
                kind = FR_TRUNC;
            end else if (r < 62) begin
                kind = FR_SMALL_LEN;
            end else if (r < 80) begin
                kind = FR_BAD_FIELD;
            end else if (r < 90) begin
                kind = FR_SHORT;
            end else begin
                kind = FR_NOISE;
            end
            make_frame(kind);
            send_frame();
            n++;
        end
    endtask

    // Main sequence.
    initial begin
        udp_ff_pkg::cfg_t c;
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-byte frames at both byte extremes, then a non-IPv4 header.
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        frame_q.push_back(ETHERTYPE_V6[15:8]);
        frame_q.push_back(ETHERTYPE_V6[7:0]);
        send_frame();

        // Reset settings first, then all zeros, all ones and random values.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 1) begin
                c = '0;
                apply_settings(c);
            end else if (ph == 2) begin
                c = '1;
                apply_settings(c);
            end else if (ph > 2) begin
                c.local_ip   = $urandom;
                c.peer_ip    = $urandom;
                c.local_port = 16'($urandom);
                c.peer_port  = 16'($urandom);
                apply_settings(c);
            end
            run_frames(PHASE_BYTES, ph == 0);
        end

        wait_idle();
        tracker.report_leftovers();
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* udp_frame_filter_core.f */
hdl/udp_ff_pkg.sv
hdl/udp_ff_cfg.sv
hdl/udp_ff_in_reg.sv
hdl/udp_ff_parse.sv
hdl/udp_ff_out_reg.sv
hdl/udp_frame_filter_core.sv
tb/udp_frame_filter_core_tb.sv
